// ===== design/size_weighted_lru_cache_defines.svh =====
// Assertion macros shared by the cache RTL.
`ifndef SIZE_WEIGHTED_LRU_CACHE_DEFINES_SVH
`define SIZE_WEIGHTED_LRU_CACHE_DEFINES_SVH

// Check on every edge out of reset.
`define SWLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every edge, reset included.
`define SWLC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/swlc_pkg.sv =====
`timescale 1ns / 1ps
package swlc_pkg;

  localparam int Entries  = 16;
  localparam int SlotW    = $clog2(Entries);
  localparam int CntW     = $clog2(Entries + 1);
  localparam int KeyBits  = 32;
  localparam int SizeW    = 32;
  localparam int TotalW   = 36;
  localparam int PAddrW   = 4;
  localparam int PDataW   = 64;

  typedef enum logic [1:0] {
    KIND_LOOKUP     = 2'd0,
    KIND_INSERT     = 2'd1,
    KIND_INVALIDATE = 2'd2,
    KIND_TRIM       = 2'd3
  } kind_e;

  typedef enum logic {
    RES_ANSWER = 1'b0,
    RES_NOTICE = 1'b1
  } res_kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_HIT_EVICT,
    S_PLACE,
    S_READ_OLD,
    S_OLD_EVICT,
    S_INSERT,
    S_SHRINK,
    S_ANSWER
  } state_e;

  localparam logic [PAddrW-1:0] AddrMaxTotal = '0;

  typedef struct packed {
    kind_e              kind;
    logic [KeyBits-1:0] key;
    logic [SizeW-1:0]   item_size;
    logic               changed;
  } req_t;

  typedef struct packed {
    res_kind_e          result_kind;
    logic [KeyBits-1:0] result_key;
    logic               hit;
    logic [SizeW-1:0]   evicted_size;
    logic [TotalW-1:0]  used_total;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic [KeyBits-1:0] key;
    logic [SizeW-1:0]   size;
  } slot_t;

endpackage

// ===== design/size_weighted_lru_cache.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// request   in         in_valid_i / in_ready_o  in_req_i  (swlc_pkg::req_t)
// result    out        out_valid_o/ out_ready_i out_rsp_o (swlc_pkg::rsp_t)
// config    in         APB psel/penable/pwrite  max_total at address 0
//
// One request at a time. A lookup, insert or invalidate scans the key/size
// memory one slot a cycle (up to all 16 slots, slot 0 read on accept).
// Evicting a hit entry retires it directly; evicting the oldest entry takes
// a read step and a retire step, plus one limit check per round while
// trimming. Evict and answer steps wait while the result side stalls.
// Reset clears valid bits, ranks, the running total and max_total; the
// key/size memory is not cleared and its data is used only for valid slots.
// A new request is taken while the last answer still waits in the output
// register.
`include "size_weighted_lru_cache_defines.svh"
module size_weighted_lru_cache (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  swlc_pkg::req_t               in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output swlc_pkg::rsp_t               out_rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [swlc_pkg::PAddrW-1:0]  paddr,
  input  logic [swlc_pkg::PDataW-1:0]  pwdata,
  output logic [swlc_pkg::PDataW-1:0]  prdata,
  output logic                         pready
);

  // Key/size store: one write port, one registered read port.
  swlc_pkg::slot_t                mem [swlc_pkg::Entries];
  swlc_pkg::slot_t                rdata_q;
  logic                           rd_en;
  logic [swlc_pkg::SlotW-1:0]     rd_addr;
  logic                           wr_en;
  logic [swlc_pkg::SlotW-1:0]     wr_addr;
  swlc_pkg::slot_t                wr_data;

  // Recency ranks and valid bits live in flops next to the control.
  swlc_pkg::state_e               state_q, state_d;
  swlc_pkg::req_t                 req_q, req_d;
  logic                           valid_q [swlc_pkg::Entries];
  logic                           valid_d [swlc_pkg::Entries];
  logic [swlc_pkg::SlotW-1:0]     rank_q  [swlc_pkg::Entries];
  logic [swlc_pkg::SlotW-1:0]     rank_d  [swlc_pkg::Entries];
  logic [swlc_pkg::CntW-1:0]      count_q, count_d;
  logic [swlc_pkg::TotalW-1:0]    total_q, total_d;
  logic [swlc_pkg::TotalW-1:0]    max_total_q;
  logic [swlc_pkg::SlotW-1:0]     slot_q, slot_d;
  logic [swlc_pkg::SlotW-1:0]     idx_q, idx_d;
  logic                           hit_q, hit_d;
  logic                           pre_q, pre_d;
  swlc_pkg::rsp_t                 out_q, out_d;
  logic                           out_valid_q, out_valid_d;

  logic                           can_emit;
  logic                           match;
  logic [swlc_pkg::SlotW-1:0]     oldest;
  logic [swlc_pkg::SlotW-1:0]     free_slot;
  logic                           do_evict;
  logic [swlc_pkg::TotalW:0]      sum;
  logic                           cfg_wr;
  logic [swlc_pkg::Entries-1:0]   valid_vec;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr == swlc_pkg::AddrMaxTotal) ?
                  swlc_pkg::PDataW'(max_total_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_total_q <= '0;
    end else if (cfg_wr && paddr == swlc_pkg::AddrMaxTotal) begin
      max_total_q <= pwdata[swlc_pkg::TotalW-1:0];
    end
  end

  assign can_emit    = !out_valid_q || out_ready_i;
  assign match       = valid_q[idx_q] && (rdata_q.key == req_q.key);
  assign in_ready_o  = (state_q == swlc_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Oldest valid slot carries rank count-1; first free slot by priority.
  always_comb begin
    oldest    = '0;
    free_slot = '0;
    for (int i = 0; i < swlc_pkg::Entries; i++) begin
      if (valid_q[i] &&
          {1'b0, rank_q[i]} == swlc_pkg::CntW'(count_q - swlc_pkg::CntW'(1))) begin
        oldest = swlc_pkg::SlotW'(i);
      end
    end
    for (int i = swlc_pkg::Entries - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = swlc_pkg::SlotW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < swlc_pkg::Entries; i++) begin
      valid_vec[i] = valid_q[i];
    end
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    valid_d     = valid_q;
    rank_d      = rank_q;
    count_d     = count_q;
    total_d     = total_q;
    slot_d      = slot_q;
    idx_d       = idx_q;
    hit_d       = hit_q;
    pre_d       = pre_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = free_slot;
    wr_data     = '{key: req_q.key, size: req_q.item_size};
    do_evict    = 1'b0;
    sum         = {1'b0, total_q} + swlc_pkg::TotalW'(req_q.item_size);

    case (state_q)
      swlc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_req_i;
          idx_d = '0;
          hit_d = 1'b0;
          pre_d = 1'b0;
          if (in_req_i.kind == swlc_pkg::KIND_TRIM) begin
            state_d = swlc_pkg::S_SHRINK;
          end else begin
            rd_en   = 1'b1;
            state_d = swlc_pkg::S_SCAN;
          end
        end
      end
      swlc_pkg::S_SCAN: begin
        if (match) begin
          slot_d = idx_q;
          if (req_q.kind == swlc_pkg::KIND_INVALIDATE) begin
            state_d = swlc_pkg::S_HIT_EVICT;
          end else begin
            // Move the hit entry to the front.
            for (int i = 0; i < swlc_pkg::Entries; i++) begin
              if (valid_q[i] && rank_q[i] < rank_q[idx_q]) begin
                rank_d[i] = rank_q[i] + swlc_pkg::SlotW'(1);
              end
            end
            rank_d[idx_q] = '0;
            if (req_q.changed) begin
              state_d = swlc_pkg::S_HIT_EVICT;
            end else begin
              hit_d   = 1'b1;
              state_d = swlc_pkg::S_ANSWER;
            end
          end
        end else if (idx_q == swlc_pkg::SlotW'(swlc_pkg::Entries - 1)) begin
          state_d = (req_q.kind == swlc_pkg::KIND_INSERT) ?
                    swlc_pkg::S_PLACE : swlc_pkg::S_ANSWER;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_q + swlc_pkg::SlotW'(1);
          idx_d   = idx_q + swlc_pkg::SlotW'(1);
        end
      end
      swlc_pkg::S_HIT_EVICT: begin
        if (can_emit) begin
          do_evict = 1'b1;
          state_d  = (req_q.kind == swlc_pkg::KIND_INSERT) ?
                     swlc_pkg::S_PLACE : swlc_pkg::S_ANSWER;
        end
      end
      swlc_pkg::S_PLACE: begin
        if (count_q == swlc_pkg::CntW'(swlc_pkg::Entries)) begin
          pre_d   = 1'b1;
          state_d = swlc_pkg::S_READ_OLD;
        end else begin
          state_d = swlc_pkg::S_INSERT;
        end
      end
      swlc_pkg::S_READ_OLD: begin
        rd_en   = 1'b1;
        rd_addr = oldest;
        slot_d  = oldest;
        state_d = swlc_pkg::S_OLD_EVICT;
      end
      swlc_pkg::S_OLD_EVICT: begin
        if (can_emit) begin
          do_evict = 1'b1;
          pre_d    = 1'b0;
          state_d  = pre_q ? swlc_pkg::S_INSERT : swlc_pkg::S_SHRINK;
        end
      end
      swlc_pkg::S_INSERT: begin
        wr_en = 1'b1;
        for (int i = 0; i < swlc_pkg::Entries; i++) begin
          if (valid_q[i]) begin
            rank_d[i] = rank_q[i] + swlc_pkg::SlotW'(1);
          end
        end
        rank_d[free_slot]  = '0;
        valid_d[free_slot] = 1'b1;
        count_d = count_q + swlc_pkg::CntW'(1);
        total_d = sum[swlc_pkg::TotalW] ? '1 : sum[swlc_pkg::TotalW-1:0];
        state_d = swlc_pkg::S_SHRINK;
      end
      swlc_pkg::S_SHRINK: begin
        if (total_q > max_total_q && count_q != '0) begin
          state_d = swlc_pkg::S_READ_OLD;
        end else begin
          state_d = swlc_pkg::S_ANSWER;
        end
      end
      swlc_pkg::S_ANSWER: begin
        if (can_emit) begin
          out_valid_d        = 1'b1;
          out_d.result_kind  = swlc_pkg::RES_ANSWER;
          out_d.result_key   = (req_q.kind == swlc_pkg::KIND_TRIM) ? '0 : req_q.key;
          out_d.hit          = hit_q;
          out_d.evicted_size = '0;
          out_d.used_total   = total_q;
          out_d.last         = 1'b1;
          state_d            = swlc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = swlc_pkg::S_IDLE;
      end
    endcase

    // Retire slot_q: drop it, close the rank gap, take back its size, send a notice.
    if (do_evict) begin
      valid_d[slot_q] = 1'b0;
      rank_d[slot_q]  = '0;
      for (int i = 0; i < swlc_pkg::Entries; i++) begin
        if (valid_q[i] && rank_q[i] > rank_q[slot_q]) begin
          rank_d[i] = rank_q[i] - swlc_pkg::SlotW'(1);
        end
      end
      count_d = count_q - swlc_pkg::CntW'(1);
      if (count_q == swlc_pkg::CntW'(1)) begin
        total_d = '0;
      end else if (total_q >= swlc_pkg::TotalW'(rdata_q.size)) begin
        total_d = total_q - swlc_pkg::TotalW'(rdata_q.size);
      end else begin
        total_d = '0;
      end
      out_valid_d        = 1'b1;
      out_d.result_kind  = swlc_pkg::RES_NOTICE;
      out_d.result_key   = rdata_q.key;
      out_d.hit          = 1'b0;
      out_d.evicted_size = rdata_q.size;
      out_d.used_total   = total_d;
      out_d.last         = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swlc_pkg::S_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      hit_q       <= 1'b0;
      pre_q       <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      slot_q      <= '0;
      for (int i = 0; i < swlc_pkg::Entries; i++) begin
        valid_q[i] <= 1'b0;
        rank_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      hit_q       <= hit_d;
      pre_q       <= pre_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      slot_q      <= slot_d;
      valid_q     <= valid_d;
      rank_q      <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    out_q <= out_d;
  end

  `SWLC_ASSERT(a_count_matches_valid, count_q == swlc_pkg::CntW'($countones(valid_vec)), "count out of step with valid bits")
  `SWLC_ASSERT(a_empty_total_zero, count_q == '0 |-> total_q == '0, "empty cache with nonzero total")
  `SWLC_ASSERT(a_notice_not_last, out_valid_o && out_rsp_o.result_kind == swlc_pkg::RES_NOTICE |-> !out_rsp_o.last, "notice marked last")
  `SWLC_ASSERT(a_count_bound, count_q <= swlc_pkg::CntW'(swlc_pkg::Entries), "count above capacity")

endmodule
